@@ hw/rtl/hwhs_pkg.sv @@
// Shared types and constants for the Hall window homing sequencer.
`default_nettype none
package hwhs_pkg;

	localparam int STEP_WIDTH_DEFAULT = 16;
	localparam logic [15:0] TOTAL_STEPS_RESET = 16'd4096;
	localparam logic [9:0] ZERO_OFFSET_RESET = 10'd0;

	localparam int DIV_WIDTH = 32;
	localparam int DIVISOR_WIDTH = 16;

	localparam logic signed [10:0] DEG_SWEEP = 11'sd370;
	localparam logic signed [10:0] DEG_SEARCH_END = 11'sd60;
	localparam logic signed [10:0] DEG_RETURN = -11'sd65;

	// The reciprocal of 360 scaled by 2**36 and rounded up is exact for products below 2**27.
	localparam logic [27:0] RECIP_360 = 28'd190887436;
	localparam int RECIP_SHIFT = 36;

	localparam logic [1:0] RPM_KEEP = 2'd0;
	localparam logic [1:0] RPM_FAST = 2'd1;
	localparam logic [1:0] RPM_SLOW = 2'd2;

	localparam logic CFG_TOTAL_STEPS = 1'b0;
	localparam logic CFG_ZERO_OFFSET = 1'b1;

	typedef enum logic [3:0] {
		PH_UNKNOWN = 4'd0,
		PH_LEAVE   = 4'd1,
		PH_SEARCH  = 4'd2,
		PH_END     = 4'd3,
		PH_BACK    = 4'd4,
		PH_START   = 4'd5,
		PH_MIDDLE  = 4'd6,
		PH_OFFSET  = 4'd7,
		PH_HOMED   = 4'd8,
		PH_TIMEOUT = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_DECODE,
		SQ_MUL,
		SQ_PREP,
		SQ_DIV_GO,
		SQ_DIV_WAIT,
		SQ_FIX,
		SQ_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_DEGREES,
		JOB_END_EDGE,
		JOB_START_EDGE
	} job_t;

	typedef enum logic [1:0] {
		NK_DEGREES,
		NK_END,
		NK_START,
		NK_WINDOW
	} div_use_t;

	typedef struct packed {
		logic start;
		logic [DIV_WIDTH-1:0] dividend;
		logic [DIVISOR_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_WIDTH-1:0] quotient;
		logic [DIVISOR_WIDTH-1:0] remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/hwhs_if.sv @@
// Request and result channel interfaces of the homing sequencer.
`default_nettype none
interface hwhs_item_if;
	logic valid;
	logic ready;
	logic mode;
	logic hall_active;
	logic travel_done;
	logic signed [31:0] raw_position;
	modport source(output valid, mode, hall_active, travel_done, raw_position, input ready);
	modport sink(input valid, mode, hall_active, travel_done, raw_position, output ready);
endinterface

interface hwhs_result_if;
	logic valid;
	logic ready;
	logic cmd_stop;
	logic cmd_reset_position;
	logic [1:0] rpm_select;
	logic move_valid;
	logic move_forward;
	logic [15:0] move_steps;
	logic homing_active;
	logic is_homed;
	logic timed_out;
	modport source(output valid, cmd_stop, cmd_reset_position, rpm_select, move_valid,
		move_forward, move_steps, homing_active, is_homed, timed_out, input ready);
	modport sink(input valid, cmd_stop, cmd_reset_position, rpm_select, move_valid,
		move_forward, move_steps, homing_active, is_homed, timed_out, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hwhs_divider.sv @@
// Restoring unsigned divider that retires one quotient bit per cycle.
`default_nettype none
module hwhs_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hwhs_pkg::div_req_t req,
	output hwhs_pkg::div_rsp_t     rsp
);
	localparam int DW = hwhs_pkg::DIV_WIDTH;
	localparam int VW = hwhs_pkg::DIVISOR_WIDTH;

	logic busy_q;
	logic done_q;
	logic [$clog2(DW)-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0] trial;
	logic ge;
	logic [VW:0] diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(DW)'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;
endmodule
`default_nettype wire

@@ hw/rtl/hall_window_homing_sequencer.sv @@
// Top level of the Hall window homing sequencer.
// Each request is taken into the block and decoded against the homing phase. A degree move is
// scaled to steps by one multiply with the total step count and one multiply with a fixed
// reciprocal of 360, while an edge position is reduced modulo the total step count in a shared
// 32-step restoring divider. An end edge runs the divider once and a start edge runs it twice.
// The request side stays not ready until the result has moved into the output register, which
// then waits for the consumer on its own; a result still held there keeps the next result in
// the emit state until the consumer takes it.
`default_nettype none
module hall_window_homing_sequencer #(
	parameter int STEP_WIDTH = hwhs_pkg::STEP_WIDTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hwhs_item_if.sink        item,
	hwhs_result_if.source    result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam logic [15:0] STEP_LIM = (STEP_WIDTH >= 16) ? 16'hFFFF
		: 16'((64'd1 << STEP_WIDTH) - 64'd1);

	logic [15:0] total_q;
	logic [9:0] offset_q;
	logic [15:0] teff;

	hwhs_pkg::seq_state_t seq_q, seq_d;
	hwhs_pkg::phase_t phase_q;
	logic active_q;
	logic homed_q;
	logic [15:0] wep_q;

	logic mode_q, hall_q, done_q;
	logic signed [31:0] pos_q;

	hwhs_pkg::job_t job;
	hwhs_pkg::phase_t dec_phase;
	logic dec_stop, dec_reset, dec_active, dec_homed;
	logic [1:0] dec_rpm;
	logic signed [10:0] dec_deg;
	logic target;

	logic signed [10:0] deg_q;
	logic [26:0] prod_q;
	hwhs_pkg::div_use_t use_q;
	logic [31:0] div_a_q;
	logic [15:0] div_b_q;
	logic div_neg_q;
	hwhs_pkg::div_req_t div_req;
	hwhs_pkg::div_rsp_t div_rsp;

	logic stop_q, reset_q, mv_valid_q, mv_fwd_q;
	logic [1:0] rpm_q;
	logic [15:0] mv_steps_q;

	logic [15:0] fixed_r;
	logic [15:0] half_win;
	logic signed [16:0] win_diff;
	logic [16:0] win_abs;
	logic [10:0] deg_abs;
	logic [54:0] recip_prod;
	logic [18:0] deg_quo;
	logic [15:0] deg_steps;

	logic out_valid_q;
	logic accept;
	logic out_load;

	assign pready = 1'b1;
	assign teff = (total_q == 16'd0) ? 16'd1 : total_q;
	assign accept = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= hwhs_pkg::TOTAL_STEPS_RESET;
			offset_q <= hwhs_pkg::ZERO_OFFSET_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				hwhs_pkg::CFG_TOTAL_STEPS: total_q <= pwdata[15:0];
				hwhs_pkg::CFG_ZERO_OFFSET: offset_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			hwhs_pkg::CFG_TOTAL_STEPS: prdata = {16'd0, total_q};
			hwhs_pkg::CFG_ZERO_OFFSET: prdata = {22'd0, offset_q};
			default: prdata = '0;
		endcase
	end

	// Phase decode of the held request.
	always_comb begin
		job = hwhs_pkg::JOB_NONE;
		dec_phase = phase_q;
		dec_stop = 1'b0;
		dec_reset = 1'b0;
		dec_rpm = hwhs_pkg::RPM_KEEP;
		dec_deg = '0;
		dec_active = active_q;
		dec_homed = homed_q;
		target = (phase_q == hwhs_pkg::PH_SEARCH) || (phase_q == hwhs_pkg::PH_BACK);
		if (mode_q) begin
			if (!active_q) begin
				dec_stop = 1'b1;
				dec_reset = 1'b1;
				dec_rpm = hwhs_pkg::RPM_FAST;
				job = hwhs_pkg::JOB_DEGREES;
				dec_deg = hwhs_pkg::DEG_SWEEP;
				dec_phase = hwhs_pkg::PH_LEAVE;
				dec_active = 1'b1;
				dec_homed = 1'b0;
			end
		end else if (active_q) begin
			case (phase_q)
				hwhs_pkg::PH_UNKNOWN: begin
					dec_stop = 1'b1;
					dec_reset = 1'b1;
					dec_rpm = hwhs_pkg::RPM_FAST;
					job = hwhs_pkg::JOB_DEGREES;
					dec_deg = hwhs_pkg::DEG_SWEEP;
					dec_phase = hwhs_pkg::PH_LEAVE;
				end
				hwhs_pkg::PH_LEAVE, hwhs_pkg::PH_SEARCH, hwhs_pkg::PH_END,
				hwhs_pkg::PH_BACK, hwhs_pkg::PH_START: begin
					if (hall_q != target) begin
						if (done_q) begin
							dec_phase = hwhs_pkg::PH_TIMEOUT;
							dec_active = 1'b0;
						end
					end else begin
						dec_stop = 1'b1;
						dec_reset = 1'b1;
						case (phase_q)
							hwhs_pkg::PH_LEAVE: begin
								job = hwhs_pkg::JOB_DEGREES;
								dec_deg = hwhs_pkg::DEG_SWEEP;
								dec_phase = hwhs_pkg::PH_SEARCH;
							end
							hwhs_pkg::PH_SEARCH: begin
								dec_rpm = hwhs_pkg::RPM_SLOW;
								job = hwhs_pkg::JOB_DEGREES;
								dec_deg = hwhs_pkg::DEG_SEARCH_END;
								dec_phase = hwhs_pkg::PH_END;
							end
							hwhs_pkg::PH_END: begin
								job = hwhs_pkg::JOB_END_EDGE;
								dec_phase = hwhs_pkg::PH_BACK;
							end
							hwhs_pkg::PH_BACK: begin
								job = hwhs_pkg::JOB_END_EDGE;
								dec_phase = hwhs_pkg::PH_START;
							end
							default: begin
								dec_rpm = hwhs_pkg::RPM_FAST;
								job = hwhs_pkg::JOB_START_EDGE;
								dec_phase = hwhs_pkg::PH_MIDDLE;
							end
						endcase
					end
				end
				hwhs_pkg::PH_MIDDLE: begin
					if (done_q) begin
						dec_reset = 1'b1;
						job = hwhs_pkg::JOB_DEGREES;
						dec_deg = {offset_q[9], offset_q};
						dec_phase = hwhs_pkg::PH_OFFSET;
					end
				end
				hwhs_pkg::PH_OFFSET: begin
					if (done_q) begin
						dec_reset = 1'b1;
						dec_phase = hwhs_pkg::PH_HOMED;
						dec_active = 1'b0;
						dec_homed = 1'b1;
					end
				end
				hwhs_pkg::PH_HOMED: begin
					dec_active = 1'b0;
					dec_homed = 1'b1;
				end
				default: begin
					dec_phase = hwhs_pkg::PH_TIMEOUT;
					dec_active = 1'b0;
				end
			endcase
		end
	end

	assign fixed_r = (div_neg_q && div_rsp.remainder != 16'd0)
		? teff - div_rsp.remainder : div_rsp.remainder;
	assign win_diff = $signed({1'b0, wep_q}) - $signed({1'b0, fixed_r});
	assign win_abs = win_diff[16] ? 17'(-win_diff) : 17'(win_diff);
	assign half_win = fixed_r >> 1;
	assign deg_abs = deg_q[10] ? 11'(-deg_q) : 11'(deg_q);
	assign recip_prod = prod_q * hwhs_pkg::RECIP_360;
	assign deg_quo = recip_prod[hwhs_pkg::RECIP_SHIFT +: 19];
	assign deg_steps = (deg_quo > {3'd0, STEP_LIM}) ? STEP_LIM : deg_quo[15:0];

	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			hwhs_pkg::SQ_IDLE: if (accept) seq_d = hwhs_pkg::SQ_DECODE;
			hwhs_pkg::SQ_DECODE: begin
				case (job)
					hwhs_pkg::JOB_NONE: seq_d = hwhs_pkg::SQ_EMIT;
					hwhs_pkg::JOB_DEGREES: seq_d = hwhs_pkg::SQ_MUL;
					default: seq_d = hwhs_pkg::SQ_DIV_GO;
				endcase
			end
			hwhs_pkg::SQ_MUL: seq_d = hwhs_pkg::SQ_PREP;
			hwhs_pkg::SQ_PREP: seq_d = hwhs_pkg::SQ_EMIT;
			hwhs_pkg::SQ_DIV_GO: seq_d = hwhs_pkg::SQ_DIV_WAIT;
			hwhs_pkg::SQ_DIV_WAIT: if (div_rsp.done) seq_d = hwhs_pkg::SQ_FIX;
			hwhs_pkg::SQ_FIX: begin
				case (use_q)
					hwhs_pkg::NK_END: seq_d = hwhs_pkg::SQ_MUL;
					hwhs_pkg::NK_START: seq_d = hwhs_pkg::SQ_DIV_GO;
					default: seq_d = hwhs_pkg::SQ_EMIT;
				endcase
			end
			hwhs_pkg::SQ_EMIT: if (!out_valid_q || result.ready) seq_d = hwhs_pkg::SQ_IDLE;
			default: seq_d = hwhs_pkg::SQ_IDLE;
		endcase
	end

	always_comb begin
		item.ready = seq_q == hwhs_pkg::SQ_IDLE;
		out_load = (seq_q == hwhs_pkg::SQ_EMIT) && (!out_valid_q || result.ready);
		div_req.start = seq_q == hwhs_pkg::SQ_DIV_GO;
		div_req.dividend = div_a_q;
		div_req.divisor = div_b_q;
	end

	hwhs_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= hwhs_pkg::SQ_IDLE;
			phase_q <= hwhs_pkg::PH_UNKNOWN;
			active_q <= 1'b0;
			homed_q <= 1'b0;
			wep_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (seq_q == hwhs_pkg::SQ_DECODE) begin
				phase_q <= dec_phase;
				active_q <= dec_active;
				homed_q <= dec_homed;
			end
			if (seq_q == hwhs_pkg::SQ_FIX && use_q == hwhs_pkg::NK_END)
				wep_q <= fixed_r & STEP_LIM;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.mode;
			hall_q <= item.hall_active;
			done_q <= item.travel_done;
			pos_q <= item.raw_position;
		end
		case (seq_q)
			hwhs_pkg::SQ_DECODE: begin
				stop_q <= dec_stop;
				reset_q <= dec_reset;
				rpm_q <= dec_rpm;
				mv_valid_q <= 1'b0;
				mv_fwd_q <= 1'b0;
				mv_steps_q <= '0;
				deg_q <= dec_deg;
				use_q <= (job == hwhs_pkg::JOB_START_EDGE) ? hwhs_pkg::NK_START
					: hwhs_pkg::NK_END;
				div_a_q <= pos_q[31] ? 32'(-pos_q) : 32'(pos_q);
				div_neg_q <= pos_q[31];
				div_b_q <= teff;
			end
			hwhs_pkg::SQ_MUL: begin
				prod_q <= deg_abs * teff;
				div_neg_q <= deg_q[10];
			end
			hwhs_pkg::SQ_PREP: begin
				mv_valid_q <= 1'b1;
				mv_fwd_q <= !div_neg_q && (deg_quo != 19'd0);
				mv_steps_q <= deg_steps;
			end
			hwhs_pkg::SQ_FIX: begin
				case (use_q)
					hwhs_pkg::NK_END: deg_q <= hwhs_pkg::DEG_RETURN;
					hwhs_pkg::NK_START: begin
						use_q <= hwhs_pkg::NK_WINDOW;
						div_a_q <= {15'd0, win_abs};
						div_neg_q <= win_diff[16];
						div_b_q <= teff;
					end
					default: begin
						mv_valid_q <= 1'b1;
						mv_fwd_q <= half_win != 16'd0;
						mv_steps_q <= (half_win > STEP_LIM) ? STEP_LIM : half_win;
					end
				endcase
			end
			default: ;
		endcase
		if (out_load) begin
			result.cmd_stop <= stop_q;
			result.cmd_reset_position <= reset_q;
			result.rpm_select <= rpm_q;
			result.move_valid <= mv_valid_q;
			result.move_forward <= mv_fwd_q;
			result.move_steps <= mv_steps_q;
			result.homing_active <= active_q;
			result.is_homed <= homed_q;
			result.timed_out <= phase_q == hwhs_pkg::PH_TIMEOUT;
		end
	end

	assign result.valid = out_valid_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item.ready)
		else $error("request taken while the previous one is in progress");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> seq_q == hwhs_pkg::SQ_DIV_WAIT)
		else $error("divider finished outside a wait state");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.homing_active && (result.timed_out || result.is_homed)))
		else $error("active flag reported together with homed or timeout");

	a_emit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> seq_q == hwhs_pkg::SQ_IDLE && out_valid_q)
		else $error("result load did not complete the request");
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the Hall window homing sequencer: directed and steered random runs.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic stop;
		logic rst_pos;
		logic [1:0] rpm;
		logic mv;
		logic fwd;
		logic [15:0] steps;
		logic active;
		logic homed;
		logic tmo;
	} cmd_word_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	hwhs_item_if item();
	hwhs_result_if result();

	hall_window_homing_sequencer u_dut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [15:0] cfg_total;
	logic [9:0] cfg_offset;
	hwhs_pkg::phase_t ph;
	logic act_q, homed_q;
	logic [15:0] win_end_q;

	cmd_word_t cmd_queue[$];
	int errors = 0;
	int homed_runs = 0;
	int timeouts = 0;
	int results_seen = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit hold_off = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint eff_total();
		return (cfg_total == 0) ? 1 : longint'(cfg_total);
	endfunction

	function automatic longint wrap_pos(longint p);
		longint r;
		r = p % eff_total();
		if (r < 0)
			r += eff_total();
		return r;
	endfunction

	function automatic void put_steps(ref cmd_word_t c, input longint s);
		longint m;
		m = (s < 0) ? -s : s;
		if (m > 65535)
			m = 65535;
		c.mv = 1;
		c.fwd = (s > 0);
		c.steps = m[15:0];
	endfunction

	function automatic void put_degrees(ref cmd_word_t c, input longint deg);
		put_steps(c, deg * eff_total() / 360);
	endfunction

	// Advances the homing phase by one tick; returns 0 when the sequence fails.
	function automatic bit advance_phase(ref cmd_word_t c, input logic hall, input logic done,
			input longint pos);
		logic target;
		longint st, w;
		case (ph)
			hwhs_pkg::PH_UNKNOWN: begin
				c.stop = 1; c.rst_pos = 1; c.rpm = hwhs_pkg::RPM_FAST;
				put_degrees(c, 370);
				ph = hwhs_pkg::PH_LEAVE;
				return 1;
			end
			hwhs_pkg::PH_LEAVE, hwhs_pkg::PH_SEARCH, hwhs_pkg::PH_END, hwhs_pkg::PH_BACK,
			hwhs_pkg::PH_START: begin
				target = (ph == hwhs_pkg::PH_SEARCH || ph == hwhs_pkg::PH_BACK);
				if (hall != target)
					return !done;
				c.stop = 1; c.rst_pos = 1;
				if (ph == hwhs_pkg::PH_LEAVE) begin
					put_degrees(c, 370);
					ph = hwhs_pkg::PH_SEARCH;
				end else if (ph == hwhs_pkg::PH_SEARCH) begin
					c.rpm = hwhs_pkg::RPM_SLOW;
					put_degrees(c, 60);
					ph = hwhs_pkg::PH_END;
				end else if (ph == hwhs_pkg::PH_END || ph == hwhs_pkg::PH_BACK) begin
					win_end_q = 16'(wrap_pos(pos));
					put_degrees(c, -65);
					ph = (ph == hwhs_pkg::PH_END) ? hwhs_pkg::PH_BACK : hwhs_pkg::PH_START;
				end else begin
					st = wrap_pos(pos);
					w = wrap_pos(longint'(win_end_q) - st);
					c.rpm = hwhs_pkg::RPM_FAST;
					put_steps(c, w / 2);
					ph = hwhs_pkg::PH_MIDDLE;
				end
				return 1;
			end
			hwhs_pkg::PH_MIDDLE: begin
				if (!done)
					return 1;
				c.rst_pos = 1;
				put_degrees(c, longint'($signed(cfg_offset)));
				ph = hwhs_pkg::PH_OFFSET;
				return 1;
			end
			hwhs_pkg::PH_OFFSET: begin
				if (!done)
					return 1;
				c.rst_pos = 1;
				ph = hwhs_pkg::PH_HOMED;
				return 1;
			end
			hwhs_pkg::PH_HOMED: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic cmd_word_t predict_command(logic mode, logic hall, logic done,
			logic signed [31:0] raw);
		cmd_word_t c;
		c = '0;
		if (mode) begin
			if (!act_q) begin
				c.stop = 1;
				homed_q = 0;
				ph = hwhs_pkg::PH_UNKNOWN;
				void'(advance_phase(c, hall, done, longint'(raw)));
				act_q = 1;
			end
		end else if (act_q) begin
			if (!advance_phase(c, hall, done, longint'(raw))) begin
				ph = hwhs_pkg::PH_TIMEOUT;
				act_q = 0;
				timeouts++;
			end else if (ph == hwhs_pkg::PH_HOMED) begin
				act_q = 0;
				homed_q = 1;
				homed_runs++;
			end
		end
		c.active = act_q;
		c.homed = homed_q;
		c.tmo = (ph == hwhs_pkg::PH_TIMEOUT);
		return c;
	endfunction

	always @(posedge clk) begin
		if (hold_off)
			result.ready <= 0;
		else
			result.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		cmd_word_t e, a;
		if (arst_n && result.valid && result.ready) begin
			a = {result.cmd_stop, result.cmd_reset_position, result.rpm_select,
				result.move_valid, result.move_forward, result.move_steps,
				result.homing_active, result.is_homed, result.timed_out};
			results_seen++;
			if (cmd_queue.size() == 0) begin
				$error("unexpected result %h", a);
				errors++;
			end else begin
				e = cmd_queue.pop_front();
				if (e != a) begin
					errors++;
					if (e.stop != a.stop)
						$error("cmd_stop exp %0d got %0d", e.stop, a.stop);
					if (e.rst_pos != a.rst_pos)
						$error("cmd_reset_position exp %0d got %0d", e.rst_pos, a.rst_pos);
					if (e.rpm != a.rpm)
						$error("rpm_select exp %0d got %0d", e.rpm, a.rpm);
					if (e.mv != a.mv)
						$error("move_valid exp %0d got %0d", e.mv, a.mv);
					if (e.fwd != a.fwd)
						$error("move_forward exp %0d got %0d", e.fwd, a.fwd);
					if (e.steps != a.steps)
						$error("move_steps exp %0d got %0d", e.steps, a.steps);
					if (e.active != a.active)
						$error("homing_active exp %0d got %0d", e.active, a.active);
					if (e.homed != a.homed)
						$error("is_homed exp %0d got %0d", e.homed, a.homed);
					if (e.tmo != a.tmo)
						$error("timed_out exp %0d got %0d", e.tmo, a.tmo);
				end
			end
		end
	end

	task automatic send_request(logic mode, logic hall, logic done, logic signed [31:0] raw);
		while ($urandom_range(99) < src_idle_pct) begin
			item.valid <= 0;
			@(posedge clk);
		end
		item.valid <= 1;
		item.mode <= mode;
		item.hall_active <= hall;
		item.travel_done <= done;
		item.raw_position <= raw;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		cmd_queue.push_back(predict_command(mode, hall, done, raw));
	endtask

	task automatic wait_idle();
		item.valid <= 0;
		@(posedge clk);
		while (cmd_queue.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
		if (addr == 3'd0)
			cfg_total = data[15:0];
		else
			cfg_offset = data[9:0];
	endtask

	task automatic set_config(logic [15:0] total, logic signed [9:0] offs);
		wait_idle();
		write_reg(3'd0, {16'h0, total});
		write_reg(3'd4, {{22{offs[9]}}, offs});
	endtask

	task automatic home_full(logic signed [31:0] end_pos, logic signed [31:0] start_pos);
		send_request(1, 0, 0, 0);
		send_request(0, 0, 0, 32'sd100);
		send_request(0, 1, 0, -32'sd7);
		send_request(0, 1, 0, end_pos);
		send_request(0, 0, 0, end_pos);
		send_request(0, 1, 0, start_pos);
		send_request(0, 0, 0, start_pos);
		send_request(0, 1, 0, start_pos);
		send_request(0, 0, 1, start_pos);
		send_request(0, 1, 0, 0);
		send_request(0, 1, 1, 0);
	endtask

	task automatic test_directed();
		send_request(0, 1, 1, 32'sd5);
		home_full(32'sd150, -32'sd40);
		send_request(1, 1, 1, 32'h7fffffff);
		send_request(0, 0, 1, 32'h7fffffff);
		send_request(1, 0, 0, 0);
		send_request(0, 1, 1, 32'h80000000);
		send_request(0, 1, 1, 0);
		send_request(1, 1, 1, 32'hffffffff);
		home_full(32'sd300, 32'sd300);
		home_full(32'h80000000, 32'h7fffffff);
	endtask

	task automatic test_register_extremes();
		set_config(16'd65535, 10'sd359);
		home_full(-32'sd1, 32'sd65534);
		set_config(16'd1, -10'sd359);
		home_full(32'sd12345, -32'sd3);
		set_config(16'd0, 10'sd1);
		home_full(32'sd9, 32'sd2);
		set_config(16'd4096, -10'sd1);
		home_full(32'sd4100, -32'sd100);
	endtask

	// Drives the phase's wanted sensor level on one random tick in three and the other level otherwise.
	task automatic random_requests(int n);
		logic target, hall, done, mode;
		logic signed [31:0] raw;
		repeat (n) begin
			mode = act_q ? ($urandom_range(39) == 0) : ($urandom_range(3) != 0);
			target = (ph == hwhs_pkg::PH_SEARCH || ph == hwhs_pkg::PH_BACK);
			hall = ($urandom_range(2) == 0) ? target : ~target;
			done = ($urandom_range(3) == 0);
			if (ph == hwhs_pkg::PH_MIDDLE || ph == hwhs_pkg::PH_OFFSET)
				done = 1'($urandom_range(1));
			if ($urandom_range(3) == 0)
				raw = $urandom;
			else
				raw = $signed(32'($urandom_range(20000))) - 32'sd10000;
			send_request(mode, hall, done, raw);
		end
	endtask

	task automatic test_random_traffic();
		src_idle_pct = 31; snk_idle_pct = 69;
		random_requests(450);
		set_config(16'($urandom_range(1, 65535)), 10'($signed($urandom_range(718)) - 359));
		src_idle_pct = 69; snk_idle_pct = 31;
		random_requests(450);
		set_config(16'($urandom_range(100, 8000)), 10'($signed($urandom_range(718)) - 359));
		src_idle_pct = 0; snk_idle_pct = 0;
		random_requests(400);
	endtask

	task automatic test_output_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			random_requests(30);
		join
	endtask

	initial begin
		arst_n = 0;
		item.valid = 0; item.mode = 0; item.hall_active = 0; item.travel_done = 0;
		item.raw_position = 0;
		result.ready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		cfg_total = hwhs_pkg::TOTAL_STEPS_RESET; cfg_offset = hwhs_pkg::ZERO_OFFSET_RESET;
		ph = hwhs_pkg::PH_UNKNOWN; act_q = 0; homed_q = 0; win_end_q = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();
		wait_idle();
		$display("Checked %0d results; %0d homing runs completed, %0d ended in timeout.",
			results_seen, homed_runs, timeouts);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
